// ----- hw/rtl/gtk_pkg.sv -----
package gtk_pkg;

    // Default depth of the top list
    localparam int MAX_TOP_DEF = 8;

    // Field widths
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 16;
    localparam int CFG_W   = 4;
    localparam int OUT_W   = VALUE_W + COUNT_W;

    // top_count after reset
    localparam logic [CFG_W-1:0] TOP_COUNT_RST = 4'd3;

    // Group counter saturates here
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // Controller states
    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_DRAIN = 3'b010,
        ST_DONE  = 3'b100
    } state_t;

    // Commands broadcast to every cell of the chain
    typedef struct packed {
        logic insert;   // place sum into the list, lower entries move down
        logic drain;    // every cell takes its right neighbor's entry
        logic clear;    // every cell goes to zero
    } cell_ctl_t;

endpackage

// ----- hw/rtl/gtk_cell.sv -----
module gtk_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gtk_pkg::cell_ctl_t          ctl,
    input  logic                        active,
    input  logic [gtk_pkg::VALUE_W-1:0] sum,
    input  logic [gtk_pkg::VALUE_W-1:0] left_entry,
    input  logic                        left_greater,
    input  logic [gtk_pkg::VALUE_W-1:0] right_entry,
    output logic [gtk_pkg::VALUE_W-1:0] entry,
    output logic                        greater
);
    import gtk_pkg::*;

    logic [VALUE_W-1:0] entry_reg;
    logic [VALUE_W-1:0] entry_next;

    // The list is kept descending, so greater rises once along the chain:
    // the first cell with greater set takes the sum, the ones after it
    // take their left neighbor.
    assign greater = active & (sum > entry_reg);
    assign entry   = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.clear)
        begin
            entry_next = '0;
        end
        else if (ctl.drain)
        begin
            entry_next = right_entry;
        end
        else if (ctl.insert && active)
        begin
            if (left_greater)
            begin
                entry_next = left_entry;
            end
            else if (greater)
            begin
                entry_next = sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

// ----- hw/rtl/group_sum_top_k_tracker.sv -----
// Channel   Dir  Word
// s_axis    in   tdata = value[31:0], tuser = group_end, tlast = stream_end
// m_axis    out  tdata = top_sum[31:0], group_count[47:32]
// cfg       in   cfg_we / cfg_data = top_count[3:0]
//
// A new word is taken every cycle while the block is in ST_RUN.
// A word with tlast (k = active list length) is accepted, then the chain of
// cells shifts its k entries toward cell 0 one per cycle into one adder, then
// the total moves to the output register and the chain is cleared.
// Reset clears the list, sums and count; top_count returns to 3.
// A stalled m_axis holds the block in its final state until the word is taken.
module group_sum_top_k_tracker #(
    parameter int MAX_TOP = gtk_pkg::MAX_TOP_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [gtk_pkg::VALUE_W-1:0] s_axis_tdata,   // value
    input  logic                        s_axis_tuser,   // group_end
    input  logic                        s_axis_tlast,   // stream_end
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [gtk_pkg::OUT_W-1:0]   m_axis_tdata,   // top_sum, group_count
    input  logic                        cfg_we,
    input  logic [gtk_pkg::CFG_W-1:0]   cfg_data        // top_count
);
    import gtk_pkg::*;

    localparam int KW = $clog2(MAX_TOP + 1);
    localparam int CW = (KW > CFG_W) ? KW : CFG_W;

    logic [CFG_W-1:0]   top_count_reg;
    logic [VALUE_W-1:0] run_sum_reg,   run_sum_next;
    logic [COUNT_W-1:0] count_reg,     count_next;
    logic [VALUE_W-1:0] acc_reg,       acc_next;
    logic [KW-1:0]      drain_cnt_reg, drain_cnt_next;
    state_t             state_reg,     state_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   out_data_reg,  out_data_next;

    logic [KW-1:0]      k_len;
    logic [CW-1:0]      tc_ext;
    logic [VALUE_W-1:0] group_sum;
    logic               accept;
    logic               closes;
    logic               out_free;
    cell_ctl_t          ctl;
    logic [VALUE_W-1:0] entry_w   [MAX_TOP];
    logic               greater_w [MAX_TOP];
    logic [MAX_TOP-1:0] active_w;

    // Active list length: top_count clamped to 1..MAX_TOP
    always_comb
    begin
        tc_ext = CW'(top_count_reg);
        if (tc_ext == '0)
        begin
            k_len = KW'(1);
        end
        else if (tc_ext > CW'(MAX_TOP))
        begin
            k_len = KW'(MAX_TOP);
        end
        else
        begin
            k_len = KW'(tc_ext);
        end
    end

    assign accept    = s_axis_tvalid & s_axis_tready;
    assign closes    = s_axis_tuser | s_axis_tlast;
    assign group_sum = run_sum_reg + s_axis_tdata;
    assign out_free  = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ST_RUN);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Chain commands
    always_comb
    begin
        ctl.insert = accept && closes;
        ctl.drain  = (state_reg == ST_DRAIN);
        ctl.clear  = (state_reg == ST_DONE) && out_free;
    end

    // Row of cells, one list entry each
    for (genvar j = 0; j < MAX_TOP; j++)
    begin : g_cell
        logic [VALUE_W-1:0] left_e;
        logic               left_g;
        logic [VALUE_W-1:0] right_e;

        assign active_w[j] = (KW'(j) < k_len);

        if (j == 0)
        begin : g_first
            assign left_e = '0;
            assign left_g = 1'b0;
        end
        else
        begin : g_mid
            assign left_e = entry_w[j-1];
            assign left_g = greater_w[j-1];
        end

        if (j == MAX_TOP - 1)
        begin : g_last
            assign right_e = '0;
        end
        else
        begin : g_inner
            assign right_e = entry_w[j+1];
        end

        gtk_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl),
            .active       (active_w[j]),
            .sum          (group_sum),
            .left_entry   (left_e),
            .left_greater (left_g),
            .right_entry  (right_e),
            .entry        (entry_w[j]),
            .greater      (greater_w[j])
        );
    end

    // Sequencer: run, drain into the adder, hand off result
    always_comb
    begin
        run_sum_next   = run_sum_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;
        drain_cnt_next = drain_cnt_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    run_sum_next = group_sum;
                    if (closes)
                    begin
                        run_sum_next = '0;
                        if (count_reg != COUNT_MAX)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    if (s_axis_tlast)
                    begin
                        acc_next       = '0;
                        drain_cnt_next = k_len - 1'b1;
                        state_next     = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                acc_next       = acc_reg + entry_w[0];
                drain_cnt_next = drain_cnt_reg - 1'b1;
                if (drain_cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {count_reg, acc_reg};
                    count_next     = '0;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_count_reg <= TOP_COUNT_RST;
            run_sum_reg   <= '0;
            count_reg     <= '0;
            acc_reg       <= '0;
            drain_cnt_reg <= '0;
            state_reg     <= ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                top_count_reg <= cfg_data;
            end
            run_sum_reg   <= run_sum_next;
            count_reg     <= count_next;
            acc_reg       <= acc_next;
            drain_cnt_reg <= drain_cnt_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output word, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule
